@@ hw/rtl/assert_macros.svh @@
// Assertion helpers for the dew point block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define DPM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dew point check failed");

// Next-cycle implication, off during reset.
`define DPM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dew point check failed");

// Next-cycle implication that also runs while reset is applied.
`define DPM_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("dew point check failed");

`endif

@@ hw/rtl/dpm_pkg.sv @@
package dpm_pkg;

  localparam int DEF_LOG_TABLE_ENTRIES = 64;
  localparam int DEF_FRAC_BITS         = 16;

  localparam int TEMP_W = 15;
  localparam int HUM_W  = 14;
  localparam int DEW_W  = 15;
  localparam int E_W    = 4;   // top bit position of humidity, 0..13
  localparam int M_W    = 13;  // humidity below its top bit

  localparam int RH_FULL = 10000;
  localparam int B_HUND  = 24304;  // b in hundredths
  localparam int A_MUL   = 141;    // a * 8
  localparam int DEW_MIN = -8000;
  localparam int DEW_MAX = 12500;

  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  function automatic logic [63:0] ln2_qf(input int f);
    return (LN2_Q32 + (64'd1 << (31 - f))) >> (32 - f);
  endfunction

  // ln(1 + i/n) in Qf; elaboration only
  function automatic logic [63:0] ln_tab_val(input int i, input int n, input int f);
    logic [63:0] v;
    logic [63:0] lg;
    int k;
    v  = (64'd1 << 30) + ((64'(i) << 30) / 64'(n));
    lg = 64'd0;
    if (v >= (64'd1 << 31)) begin
      lg = 64'd1 << 30;
      v  = v >> 1;
    end
    for (k = 1; k <= 30; k++) begin
      v = (v * v) >> 30;
      if (v >= (64'd1 << 31)) begin
        v  = v >> 1;
        lg = lg | (64'd1 << (30 - k));
      end
    end
    return (lg * LN2_Q32 + (64'd1 << (61 - f))) >> (62 - f);
  endfunction

  // ln(10000) by the same normalize and interpolate steps as the datapath
  function automatic logic [63:0] ln_full_val(input int n, input int f);
    logic [63:0] h;
    logic [63:0] p;
    logic [63:0] idx;
    logic [63:0] r;
    logic [63:0] lo;
    logic [63:0] hi;
    int e;
    int k;
    h = 64'(RH_FULL);
    e = 0;
    for (k = 0; k < 31; k++) begin
      if ((h >> (k + 1)) != 64'd0) e = k + 1;
    end
    p   = (h - (64'd1 << e)) * 64'(n);
    idx = p >> e;
    r   = p & ((64'd1 << e) - 64'd1);
    lo  = ln_tab_val(int'(idx), n, f);
    hi  = ln_tab_val(int'(idx) + 1, n, f);
    return 64'(e) * ln2_qf(f) + lo + (((hi - lo) * r) >> e);
  endfunction

endpackage

@@ hw/rtl/dpm_log.sv @@
module dpm_log #(
  parameter int N  = dpm_pkg::DEF_LOG_TABLE_ENTRIES,
  parameter int F  = dpm_pkg::DEF_FRAC_BITS,
  parameter int PW = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            ce,
  input  logic                            in_valid,
  input  logic [dpm_pkg::HUM_W-1:0]       in_hum,
  input  logic [PW-1:0]                   in_pay,
  output logic                            out_valid,
  output logic signed [F+5:0]             out_ln,   // ln(h) - ln(10000), Qf
  output logic [PW-1:0]                   out_pay
);
  import dpm_pkg::*;

  localparam int TIW = $clog2(N + 1);
  localparam int TW  = F;
  localparam int PBW = M_W + TIW;
  localparam int PRW = TW + M_W;
  localparam int LNW = F + 5;
  localparam logic [TW-1:0]  LN2_QF = TW'(ln2_qf(F));
  localparam logic [LNW-1:0] LNF    = LNW'(ln_full_val(N, F));

  logic [TW-1:0] tab [0:N];
  for (genvar gi = 0; gi <= N; gi++) begin : g_tab
    assign tab[gi] = TW'(ln_tab_val(gi, N, F));
  end

  // stage 1: normalize
  logic           v1_r;
  logic [E_W-1:0] e1_r, e1_nxt;
  logic [M_W-1:0] m1_r, m1_nxt;
  logic [PW-1:0]  pay1_r;

  always_comb begin
    e1_nxt = '0;
    for (int k = 0; k < HUM_W; k++) begin
      if (in_hum[k]) e1_nxt = E_W'(k);
    end
    m1_nxt = M_W'(in_hum - (HUM_W'(1) << e1_nxt));
  end

  // stage 2: table index and interpolation fraction
  logic           v2_r;
  logic [PBW-1:0] p2;
  logic [TIW-1:0] idx2_r, idx2_nxt;
  logic [M_W-1:0] r2_r, r2_nxt;
  logic [E_W-1:0] e2_r;
  logic [PW-1:0]  pay2_r;

  always_comb begin
    p2       = PBW'(m1_r) * PBW'(N);
    idx2_nxt = TIW'(p2 >> e1_r);
    r2_nxt   = M_W'(p2 & ((PBW'(1) << e1_r) - PBW'(1)));
  end

  // stage 3: table read
  logic           v3_r;
  logic [TW-1:0]  lo3_r, lo3_nxt, df3_r, df3_nxt;
  logic [M_W-1:0] r3_r;
  logic [E_W-1:0] e3_r;
  logic [PW-1:0]  pay3_r;

  always_comb begin
    lo3_nxt = tab[idx2_r];
    df3_nxt = tab[idx2_r + TIW'(1)] - tab[idx2_r];
  end

  // stage 4: slope times fraction
  logic           v4_r;
  logic [PRW-1:0] pr4_r, pr4_nxt;
  logic [TW-1:0]  lo4_r;
  logic [E_W-1:0] e4_r;
  logic [PW-1:0]  pay4_r;

  assign pr4_nxt = PRW'(df3_r) * PRW'(r3_r);

  // stage 5: assemble
  logic               v5_r;
  logic [LNW-1:0]     ln5;
  logic signed [F+5:0] ln5_r, ln5_nxt;
  logic [PW-1:0]      pay5_r;

  always_comb begin
    ln5     = LNW'(e4_r) * LNW'(LN2_QF) + LNW'(lo4_r) + LNW'(pr4_r >> e4_r);
    ln5_nxt = $signed({1'b0, ln5}) - $signed({1'b0, LNF});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      e1_r   <= e1_nxt;
      m1_r   <= m1_nxt;
      pay1_r <= in_pay;
      idx2_r <= idx2_nxt;
      r2_r   <= r2_nxt;
      e2_r   <= e1_r;
      pay2_r <= pay1_r;
      lo3_r  <= lo3_nxt;
      df3_r  <= df3_nxt;
      r3_r   <= r2_r;
      e3_r   <= e2_r;
      pay3_r <= pay2_r;
      pr4_r  <= pr4_nxt;
      lo4_r  <= lo3_r;
      e4_r   <= e3_r;
      pay4_r <= pay3_r;
      ln5_r  <= ln5_nxt;
      pay5_r <= pay4_r;
    end
  end

  assign out_valid = v5_r;
  assign out_ln    = ln5_r;
  assign out_pay   = pay5_r;

endmodule

@@ hw/rtl/dpm_div.sv @@
// Unsigned restoring divider, one quotient bit per stage.
// The quotient must fit in QW bits.
module dpm_div #(
  parameter int NW = 40,
  parameter int DW = 19,
  parameter int QW = 22,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          ce,
  input  logic          in_valid,
  input  logic [NW-1:0] in_num,
  input  logic [DW-1:0] in_den,
  input  logic [PW-1:0] in_pay,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [PW-1:0] out_pay
);
  import dpm_pkg::*;

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [NW-1:0] rem_i [0:QW-1];
  logic [DW-1:0] den_i [0:QW-1];
  logic [QW-1:0] quo_i [0:QW-1];
  logic [PW-1:0] pay_i [0:QW-1];
  logic          vld_i [0:QW-1];

  logic [NW-1:0] rem_r [1:QW];
  logic [DW-1:0] den_r [1:QW];
  logic [QW-1:0] quo_r [1:QW];
  logic [PW-1:0] pay_r [1:QW];
  logic          vld_r [1:QW];

  for (genvar s = 0; s < QW; s++) begin : g_stg
    localparam int J = QW - 1 - s;
    logic [CW-1:0] sh;
    logic          ge;

    if (s == 0) begin : g_head
      assign rem_i[s] = in_num;
      assign den_i[s] = in_den;
      assign quo_i[s] = '0;
      assign pay_i[s] = in_pay;
      assign vld_i[s] = in_valid;
    end else begin : g_body
      assign rem_i[s] = rem_r[s];
      assign den_i[s] = den_r[s];
      assign quo_i[s] = quo_r[s];
      assign pay_i[s] = pay_r[s];
      assign vld_i[s] = vld_r[s];
    end

    assign sh = CW'(den_i[s]) << J;
    assign ge = CW'(rem_i[s]) >= sh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (ce) begin
        vld_r[s+1] <= vld_i[s];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[s+1] <= ge ? NW'(CW'(rem_i[s]) - sh) : rem_i[s];
        den_r[s+1] <= den_i[s];
        quo_r[s+1] <= ge ? (quo_i[s] | (QW'(1) << J)) : quo_i[s];
        pay_r[s+1] <= pay_i[s];
      end
    end
  end

  assign out_valid = vld_r[QW];
  assign out_quo   = quo_r[QW];
  assign out_pay   = pay_r[QW];

endmodule

@@ hw/rtl/dew_point_magnus.sv @@
// Channel | Ports                      | Contents
// in      | in_tvalid/in_tready/tdata  | temperature, humidity
// out     | out_tvalid/out_tready/...  | dew value in tdata, undefined_input in tuser
//
// One sample per clock unless a held result stalls the pipeline.
// The two restoring dividers set the depth: FRAC_BITS + 6 and 17 stages.
// rst_n is synchronous; it clears the valid bits only.
// A result held at the output stalls the whole pipeline; nothing is lost.
module dew_point_magnus #(
  parameter int LOG_TABLE_ENTRIES = dpm_pkg::DEF_LOG_TABLE_ENTRIES,
  parameter int FRAC_BITS         = dpm_pkg::DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // [14:0] temperature, [28:15] humidity, rest zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [14:0] dew value, [15] zero
  output logic [0:0]  out_tuser    // [0] undefined_input
);
  import dpm_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int AW  = F + 8;
  localparam int LGW = F + 6;
  localparam int NW1 = F + 23;
  localparam int DW1 = 19;
  localparam int QW1 = F + 6;
  localparam int PW1 = LGW + 2;
  localparam int NW2 = F + 24;
  localparam int DW2 = F + 7;
  localparam int QW2 = 17;
  localparam int PW2 = 3;
  localparam logic signed [AW:0] A_QF = (AW + 1)'(A_MUL) <<< (F - 3);

  logic ce;
  logic out_vld_r;

  assign ce        = !out_vld_r || out_tready;
  assign in_tready = ce;

  // input register, humidity clamped
  logic                     v0_r;
  logic signed [TEMP_W-1:0] t0_r;
  logic [HUM_W-1:0]         h0_r, h_in;
  logic                     z0_r;

  assign h_in = in_tdata[TEMP_W +: HUM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) v0_r <= 1'b0;
    else if (ce) v0_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      t0_r <= $signed(in_tdata[TEMP_W-1:0]);
      h0_r <= (h_in > HUM_W'(RH_FULL)) ? HUM_W'(RH_FULL) : h_in;
      z0_r <= (h_in == '0);
    end
  end

  // log of humidity
  logic                   lg_v;
  logic signed [LGW-1:0]  lg_ln;
  logic [TEMP_W:0]        lg_pay;

  dpm_log #(.N(LOG_TABLE_ENTRIES), .F(F), .PW(TEMP_W + 1)) u_log (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (v0_r),
    .in_hum   (z0_r ? HUM_W'(1) : h0_r),
    .in_pay   ({z0_r, t0_r}),
    .out_valid(lg_v),
    .out_ln   (lg_ln),
    .out_pay  (lg_pay)
  );

  // a*T/(b+T): magnitude plus half divisor, sign kept aside
  logic signed [TEMP_W-1:0] t1;
  logic signed [16:0]       bt1;
  logic [TEMP_W-1:0]        ta1;
  logic [21:0]              m1;
  logic                     v1_r;
  logic [NW1-1:0]           n1_r;
  logic [DW1-1:0]           d1_r;
  logic [PW1-1:0]           p1_r;

  always_comb begin
    t1  = $signed(lg_pay[TEMP_W-1:0]);
    bt1 = 17'sd24304 + 17'(t1);
    ta1 = t1[TEMP_W-1] ? TEMP_W'(-t1) : TEMP_W'(t1);
    m1  = 22'(ta1) * 22'(A_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (ce) v1_r <= lg_v;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n1_r <= (NW1'(m1) << F) + NW1'({bt1[15:0], 2'b00});
      d1_r <= {bt1[15:0], 3'b000};
      p1_r <= {lg_pay[TEMP_W], t1[TEMP_W-1], lg_ln};
    end
  end

  logic           dv1_v;
  logic [QW1-1:0] dv1_q;
  logic [PW1-1:0] dv1_p;

  dpm_div #(.NW(NW1), .DW(DW1), .QW(QW1), .PW(PW1)) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (v1_r),
    .in_num   (n1_r),
    .in_den   (d1_r),
    .in_pay   (p1_r),
    .out_valid(dv1_v),
    .out_quo  (dv1_q),
    .out_pay  (dv1_p)
  );

  // alpha
  logic signed [AW-1:0] q1s, term2;
  logic                 v2_r, z2_r;
  logic signed [AW-1:0] al2_r;

  always_comb begin
    q1s   = $signed(AW'(dv1_q));
    term2 = dv1_p[LGW] ? -q1s : q1s;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (ce) v2_r <= dv1_v;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      al2_r <= AW'($signed(dv1_p[LGW-1:0])) + term2;
      z2_r  <= dv1_p[LGW+1];
    end
  end

  // b*alpha / (a - alpha)
  logic signed [AW+15:0] pr3;
  logic [AW+15:0]        pa3;
  logic signed [AW:0]    den3;
  logic                  bad3;
  logic                  v3_r;
  logic [NW2-1:0]        n3_r;
  logic [DW2-1:0]        d3_r;
  logic [PW2-1:0]        p3_r;

  always_comb begin
    pr3  = (AW + 16)'(al2_r) * (AW + 16)'(B_HUND);
    pa3  = pr3[AW+15] ? (AW + 16)'(-pr3) : (AW + 16)'(pr3);
    den3 = A_QF - (AW + 1)'(al2_r);
    bad3 = den3[AW] || (den3 == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (ce) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      n3_r <= NW2'(pa3) + NW2'(den3[DW2-1:1]);
      d3_r <= den3[DW2-1:0];
      p3_r <= {z2_r, al2_r[AW-1], bad3};
    end
  end

  logic           dv2_v;
  logic [QW2-1:0] dv2_q;
  logic [PW2-1:0] dv2_p;

  dpm_div #(.NW(NW2), .DW(DW2), .QW(QW2), .PW(PW2)) u_div_d (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_valid (v3_r),
    .in_num   (n3_r),
    .in_den   (d3_r),
    .in_pay   (p3_r),
    .out_valid(dv2_v),
    .out_quo  (dv2_q),
    .out_pay  (dv2_p)
  );

  // sign, saturate, output register
  logic signed [QW2:0]    q2s, dew4;
  logic signed [DEW_W-1:0] dew_nxt;
  logic signed [QW2:0]    lim_lo, lim_hi;
  logic signed [DEW_W-1:0] dew_r;
  logic                   undef_r;

  always_comb begin
    lim_lo = (QW2 + 1)'(DEW_MIN);
    lim_hi = (QW2 + 1)'(DEW_MAX);
    q2s    = $signed({1'b0, dv2_q});
    dew4   = dv2_p[1] ? -q2s : q2s;
    priority if (dv2_p[2]) dew_nxt = DEW_W'(DEW_MIN);
    else if (dv2_p[0])     dew_nxt = DEW_W'(DEW_MAX);
    else if (dew4 < lim_lo) dew_nxt = DEW_W'(DEW_MIN);
    else if (dew4 > lim_hi) dew_nxt = DEW_W'(DEW_MAX);
    else                   dew_nxt = DEW_W'(dew4);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld_r <= 1'b0;
    else if (ce) out_vld_r <= dv2_v;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dew_r   <= dew_nxt;
      undef_r <= dv2_p[2];
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0, dew_r};
  assign out_tuser  = undef_r;

endmodule

@@ hw/rtl/dpm_checker.sv @@
`include "assert_macros.svh"

module dpm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [0:0]  out_tuser
);

  // zero humidity reports the floor value
  `DPM_ASSERT_NOW(a_undef_min, out_tvalid && out_tuser[0], out_tdata[14:0] == 15'h60C0)
  // a held result blocks intake
  `DPM_ASSERT_NOW(a_stall_in, out_tvalid && !out_tready, !in_tready)
  // a held result stays
  `DPM_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)
  // reset empties the pipeline
  `DPM_ASSERT_NEXT_ANY(a_rst_empty, !rst_n, !out_tvalid)

endmodule

bind dew_point_magnus dpm_checker u_dpm_checker (.*);

@@ dv/tb_dew_point_magnus.sv @@
module tb_dew_point_magnus;
  timeunit 1ns;
  timeprecision 1ps;

  import dpm_pkg::*;

  localparam int TAB_N   = 64;
  localparam int FB      = 16;
  localparam int LATENCY = FB + 33;
  localparam int WD_MAX  = 20000;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [HUM_W-1:0]         hum;
  } sample_t;

  typedef struct packed {
    logic signed [DEW_W-1:0] dew;
    logic                    undef;
  } dew_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [31:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [0:0] out_tuser;

  dew_point_magnus uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  longint ln_lut [0:TAB_N];
  longint ln_rh_full;
  longint ln2_f;

  sample_t  pending_q [$];
  dew_res_t dew_exp_q [$];
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  errors = 0;
  int  wd_count = 0;
  bit  req_active = 1'b0;

  function automatic longint log_of_hum(longint h);
    longint e, p, idx, r, lo, hi;
    e = 0;
    while (e < 31 && (h >> (e + 1)) != 0) e++;
    p   = (h - (64'sd1 << e)) * TAB_N;
    idx = p >> e;
    r   = p & ((64'sd1 << e) - 1);
    if (idx >= TAB_N) idx = TAB_N - 1;
    lo = ln_lut[idx];
    hi = ln_lut[idx + 1];
    return e * ln2_f + lo + (((hi - lo) * r) >> e);
  endfunction

  function automatic void build_ln_lut();
    logic [63:0] v, lg;
    for (int i = 0; i <= TAB_N; i++) begin
      v  = (64'd1 << 30) + ((64'(i) << 30) / 64'(TAB_N));
      lg = 0;
      if (v >= (64'd1 << 31)) begin
        lg = 64'd1 << 30;
        v  = v >> 1;
      end
      for (int k = 1; k <= 30; k++) begin
        v = (v * v) >> 30;
        if (v >= (64'd1 << 31)) begin
          v  = v >> 1;
          lg = lg | (64'd1 << (30 - k));
        end
      end
      ln_lut[i] = longint'((lg * LN2_Q32 + (64'd1 << (61 - FB))) >> (62 - FB));
    end
    ln2_f = longint'((LN2_Q32 + (64'd1 << (31 - FB))) >> (32 - FB));
    ln_rh_full = log_of_hum(RH_FULL);
  endfunction

  // round to nearest, ties away from zero; d > 0
  function automatic longint div_near(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic dew_res_t magnus_dew(sample_t s);
    dew_res_t res;
    longint t, h, alpha, den, dew;
    t = s.temp;
    h = s.hum;
    if (h == 0) begin
      res.dew = DEW_W'(DEW_MIN);
      res.undef = 1'b1;
      return res;
    end
    if (h > RH_FULL) h = RH_FULL;
    alpha = log_of_hum(h) - ln_rh_full;
    alpha += div_near(A_MUL * t * (64'sd1 << FB), 8 * (B_HUND + t));
    den = A_MUL * (64'sd1 << (FB - 3)) - alpha;
    if (den <= 0) dew = DEW_MAX;
    else dew = div_near(B_HUND * alpha, den);
    if (dew < DEW_MIN) dew = DEW_MIN;
    if (dew > DEW_MAX) dew = DEW_MAX;
    res.dew = dew[DEW_W-1:0];
    res.undef = 1'b0;
    return res;
  endfunction

  function automatic void add_sample(int t, int h);
    sample_t s;
    s.temp = t[TEMP_W-1:0];
    s.hum  = h[HUM_W-1:0];
    pending_q.push_back(s);
  endfunction

  // driver
  always @(posedge clk) begin
    sample_t s;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s = pending_q.pop_front();
        dew_exp_q.push_back(magnus_dew(s));
      end
      if (req_active && (!in_tvalid || in_tready)) begin
        if (!(in_tvalid && in_tready) && in_tvalid) begin
        end else if (pending_q.size() > 0 && !(in_tvalid && in_tready && pending_q.size() == 0)
                     && $urandom_range(99) >= send_idle_pct) begin
          s = pending_q[0];
          in_tdata  <= {3'b0, s.hum, s.temp};
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    dew_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.dew = out_tdata[DEW_W-1:0];
        got.undef = out_tuser[0];
        if (dew_exp_q.size() == 0) begin
          $display("%0t: unexpected result exp=none act=%h/%b", $realtime, got.dew, got.undef);
          errors++;
        end else begin
          want = dew_exp_q.pop_front();
          if (got.dew !== want.dew) begin
            $display("%0t: dew exp=%0d act=%0d", $realtime, want.dew, got.dew);
            errors++;
          end
          if (got.undef !== want.undef) begin
            $display("%0t: undefined_input exp=%b act=%b", $realtime, want.undef, got.undef);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wd_count <= 0;
      else wd_count <= wd_count + 1;
      if (wd_count >= WD_MAX) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic run_phase(int idle_pct, int stall_pct, int n);
    int t, h;
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      t = $urandom_range(3) == 0 ? $signed($urandom_range(32767)) - 16384
                                 : $signed($urandom_range(16500)) - 4000;
      case ($urandom_range(9))
        0: h = $urandom_range(16383);
        1: h = $urandom_range(3);
        default: h = $urandom_range(10000);
      endcase
      add_sample(t, h);
    end
    while (pending_q.size() > 0 || in_tvalid) @(posedge clk);
  endtask

  initial begin
    build_ln_lut();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    req_active = 1'b1;
    // extremes, clamp, zero humidity, range edges of temperature
    add_sample(-4000, 10000); add_sample(12500, 10000); add_sample(0, 10000);
    add_sample(-4000, 1);     add_sample(12500, 1);     add_sample(2500, 0);
    add_sample(-16384, 0);    add_sample(16383, 16383); add_sample(-16384, 16383);
    add_sample(-16384, 1);    add_sample(16383, 1);     add_sample(2000, 10001);
    add_sample(2000, 5000);   add_sample(-1, 8192);     add_sample(1, 8191);
    add_sample(-1, 1);        add_sample(12500, 9999);  add_sample(-4000, 2);
    add_sample(0, 0);         add_sample(16383, 10000);
    run_phase(0, 0, 175);
    run_phase(74, 0, 175);
    run_phase(0, 74, 175);
    run_phase(37, 37, 175);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    while (dew_exp_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && dew_exp_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
